// ===== sv/assert_macros.svh =====
// Assertion macros shared by the frontier engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GSFE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gsfe assertion failed");
`define GSFE_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("gsfe forbidden condition seen");
`else
`define GSFE_ASSERT(name, clk, rst_n, prop)
`define GSFE_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ===== sv/gsfe_pkg.sv =====
// Types, codes and sizes shared by the graph search frontier engine.
package gsfe_pkg;

  localparam int MAX_NODES = 4096;
  localparam int NODE_W    = 12;
  localparam int AW        = $clog2(MAX_NODES);
  localparam int PTR_W     = AW + 1;

  typedef logic [1:0]        cmd_t;
  typedef logic [1:0]        kind_t;
  typedef logic              cfg_idx_t;
  typedef logic [NODE_W-1:0] node_t;
  typedef logic [AW-1:0]     addr_t;
  typedef logic [PTR_W-1:0]  ptr_t;

  localparam cmd_t CMD_START    = 2'd0;
  localparam cmd_t CMD_NEIGHBOR = 2'd1;
  localparam cmd_t CMD_PAGE_END = 2'd2;

  localparam kind_t KIND_FETCH     = 2'd0;
  localparam kind_t KIND_FOUND     = 2'd1;
  localparam kind_t KIND_NOT_FOUND = 2'd2;

  localparam cfg_idx_t CFG_MODE   = 1'b0;
  localparam cfg_idx_t CFG_TARGET = 1'b1;

  typedef struct packed {
    logic  mode;
    node_t target;
  } cfg_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    logic  wdata;
    addr_t raddr;
  } vis_req_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    node_t wdata;
    addr_t raddr;
  } fr_req_t;

  function automatic addr_t to_addr(input node_t node);
    return AW'(node);
  endfunction

endpackage

// ===== sv/graph_search_frontier_engine.sv =====
// Graph search frontier engine: top level with configuration registers and memories.
// Usage:
//   Input channel (in_valid / in_stall): one word carries in_cmd and
//   in_neighbor_node. A start word clears the visited map and answers with
//   a fetch of node 0 (or found, when the target is node 0). Neighbor words
//   from the fetched page go to the frontier if unseen; a page-end word pops
//   the next node and answers fetch, found or not found.
//   Output channel (out_valid / out_stall): one word per answer, held in an
//   output register with a one-deep staging slot behind it.
//   Configuration (cfg_valid / cfg_ready, always ready): index 0 search_mode
//   (0 stack / depth first, 1 queue / breadth first), index 1 target_node.
//   Write it only while no search word is in flight.
// Sequencing: a neighbor word does a visited-map read-modify-write. A page-end
//   word that pops reads the frontier, puts the node in the staging slot, then
//   moves it to the output register; on an empty frontier the answer goes straight to the staging slot.
//   A start word stages its answer, then the input stalls while the visited map
//   is swept over all MAX_NODES (4096) entries, one entry a cycle.
// Reset: no search active, frontier empty, both registers zero.
// Output stall: the answer waits in the output register; one more answer
// may wait in the staging slot, after which the input stalls.
module graph_search_frontier_engine import gsfe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  cmd_t     in_cmd,
  input  node_t    in_neighbor_node,
  output logic     out_valid,
  input  logic     out_stall,
  output kind_t    out_result_kind,
  output node_t    out_result_node,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  node_t    cfg_data
);

  logic     mode_r, mode_nxt;
  node_t    target_r, target_nxt;
  cfg_t     cfg;
  vis_req_t vis_req;
  fr_req_t  fr_req;
  logic     vis_rdata;
  node_t    fr_rdata;

  // registers take a write in any cycle
  assign cfg_ready  = 1'b1;
  assign cfg.mode   = mode_r;
  assign cfg.target = target_r;

  always_comb begin
    mode_nxt   = mode_r;
    target_nxt = target_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:   mode_nxt   = cfg_data[0];
        CFG_TARGET: target_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      target_r <= '0;
    end else begin
      mode_r   <= mode_nxt;
      target_r <= target_nxt;
    end
  end

  // visited map: one bit per node
  gsfe_ram #(
    .DEPTH (MAX_NODES),
    .WIDTH (1)
  ) u_visited (
    .clk   (clk),
    .we    (vis_req.we),
    .waddr (vis_req.waddr),
    .wdata (vis_req.wdata),
    .raddr (vis_req.raddr),
    .rdata (vis_rdata)
  );

  // frontier store: stack or queue of node ids
  gsfe_ram #(
    .DEPTH (MAX_NODES),
    .WIDTH (NODE_W)
  ) u_frontier (
    .clk   (clk),
    .we    (fr_req.we),
    .waddr (fr_req.waddr),
    .wdata (fr_req.wdata),
    .raddr (fr_req.raddr),
    .rdata (fr_rdata)
  );

  gsfe_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_neighbor_node (in_neighbor_node),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_result_node  (out_result_node),
    .vis_req          (vis_req),
    .vis_rdata        (vis_rdata),
    .fr_req           (fr_req),
    .fr_rdata         (fr_rdata)
  );

endmodule

// ===== sv/gsfe_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module gsfe_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/gsfe_ctrl.sv =====
// Search sequencer: command decode, frontier pointers, map sweep and result staging.
`include "assert_macros.svh"
module gsfe_ctrl import gsfe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  cmd_t     in_cmd,
  input  node_t    in_neighbor_node,
  output logic     out_valid,
  input  logic     out_stall,
  output kind_t    out_result_kind,
  output node_t    out_result_node,
  output vis_req_t vis_req,
  input  logic     vis_rdata,
  output fr_req_t  fr_req,
  input  node_t    fr_rdata
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_VIS   = 4'b0010,
    ST_POP   = 4'b0100,
    ST_CLEAR = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  ptr_t   head_r, head_nxt;
  ptr_t   tail_r, tail_nxt;
  logic   active_r, active_nxt;
  node_t  nb_r, nb_nxt;
  addr_t  clr_r, clr_nxt;
  logic   pend_r, pend_nxt;
  kind_t  pend_kind_r, pend_kind_nxt;
  node_t  pend_node_r, pend_node_nxt;
  logic   out_valid_r, out_valid_nxt;
  kind_t  out_kind_r, out_kind_nxt;
  node_t  out_node_r, out_node_nxt;

  logic   in_acc;
  logic   out_load;
  ptr_t   tail_m1;

  assign in_stall = !(state_r == ST_IDLE && !pend_r);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = pend_r && (!out_valid_r || !out_stall);
  assign tail_m1  = tail_r - PTR_W'(1);

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_result_node = out_node_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    active_nxt    = active_r;
    nb_nxt        = nb_r;
    clr_nxt       = clr_r;
    pend_nxt      = pend_r && !out_load;
    pend_kind_nxt = pend_kind_r;
    pend_node_nxt = pend_node_r;

    vis_req.we    = 1'b0;
    vis_req.waddr = to_addr(nb_r);
    vis_req.wdata = 1'b1;
    vis_req.raddr = to_addr(in_neighbor_node);

    fr_req.we     = 1'b0;
    fr_req.waddr  = tail_r[AW-1:0];
    fr_req.wdata  = nb_r;
    fr_req.raddr  = cfg.mode ? head_r[AW-1:0] : tail_m1[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            CMD_START: begin
              head_nxt      = '0;
              tail_nxt      = '0;
              clr_nxt       = '0;
              state_nxt     = ST_CLEAR;
              pend_nxt      = 1'b1;
              pend_node_nxt = '0;
              if (cfg.target == '0) begin
                pend_kind_nxt = KIND_FOUND;
                active_nxt    = 1'b0;
              end else begin
                pend_kind_nxt = KIND_FETCH;
                active_nxt    = 1'b1;
              end
            end
            CMD_NEIGHBOR: begin
              if (active_r && 32'(in_neighbor_node) < MAX_NODES) begin
                nb_nxt    = in_neighbor_node;
                state_nxt = ST_VIS;
              end
            end
            CMD_PAGE_END: begin
              if (active_r) begin
                if (head_r >= tail_r) begin
                  pend_nxt      = 1'b1;
                  pend_kind_nxt = KIND_NOT_FOUND;
                  pend_node_nxt = '0;
                  active_nxt    = 1'b0;
                end else begin
                  // pop address is already on the read port this cycle
                  if (cfg.mode) begin
                    head_nxt = head_r + PTR_W'(1);
                  end else begin
                    tail_nxt = tail_m1;
                  end
                  state_nxt = ST_POP;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_VIS: begin
        // mark and push only a node not seen before
        if (!vis_rdata) begin
          vis_req.we = 1'b1;
          if (32'(tail_r) < MAX_NODES) begin
            fr_req.we = 1'b1;
            tail_nxt  = tail_r + PTR_W'(1);
          end
        end
        state_nxt = ST_IDLE;
      end
      ST_POP: begin
        pend_nxt      = 1'b1;
        pend_node_nxt = fr_rdata;
        if (fr_rdata == cfg.target) begin
          pend_kind_nxt = KIND_FOUND;
          active_nxt    = 1'b0;
        end else begin
          pend_kind_nxt = KIND_FETCH;
        end
        state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        // sweep the map; the root comes out marked
        vis_req.we    = 1'b1;
        vis_req.waddr = clr_r;
        vis_req.wdata = (clr_r == '0);
        if (clr_r == AW'(MAX_NODES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_node_nxt  = out_node_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = pend_kind_r;
      out_node_nxt  = pend_node_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      active_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      active_r    <= active_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nb_r        <= nb_nxt;
    clr_r       <= clr_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_node_r <= pend_node_nxt;
    out_kind_r  <= out_kind_nxt;
    out_node_r  <= out_node_nxt;
  end

  `GSFE_ASSERT(a_head_le_tail, clk, rst_n, head_r <= tail_r)
  `GSFE_ASSERT(a_tail_cap, clk, rst_n, 32'(tail_r) <= MAX_NODES)
  `GSFE_ASSERT(a_pend_kept, clk, rst_n, pend_r && out_valid_r && out_stall |=> pend_r)
  `GSFE_ASSERT_NEVER(a_no_take_in_sweep, clk, rst_n, state_r == ST_CLEAR && !in_stall)
  `GSFE_ASSERT(a_out_from_pend, clk, rst_n, $rose(out_valid_r) |-> $past(pend_r))

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for graph_search_frontier_engine: directed and random searches.
module tb;
  import gsfe_pkg::*;

  // cmd 3 has no meaning in the block; send it as noise
  localparam cmd_t CMD_UNUSED = 2'd3;

  // two copies of the search state: one follows accepted words for checking,
  // the other runs ahead while words are planned
  localparam int MODEL_CHECK = 0;
  localparam int MODEL_PLAN  = 1;

  localparam int SETTLE_CYCLES = 16;    // extra wait for the block to go idle after the last answer; leave margin
  localparam int HOLD_CYCLES   = 5000;  // long receiver hold-off, longer than a map sweep
  localparam int QUIET_LIMIT   = 40000; // sweep + hold + gaps, taken several times over
  localparam int PHASES        = 12;
  localparam int PHASE_WORDS   = 145;

  typedef struct packed {
    cmd_t  cmd;
    node_t node;
  } search_word_t;

  typedef struct packed {
    logic  present;
    kind_t kind;
    node_t node;
  } search_answer_t;

  logic     clk;
  logic     rst_n            = 1'b0;
  logic     in_valid         = 1'b0;
  logic     in_stall;
  cmd_t     in_cmd           = CMD_START;
  node_t    in_neighbor_node = '0;
  logic     out_valid;
  logic     out_stall        = 1'b0;
  kind_t    out_result_kind;
  node_t    out_result_node;
  logic     cfg_valid        = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index        = CFG_MODE;
  node_t    cfg_data         = '0;

  graph_search_frontier_engine dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_neighbor_node (in_neighbor_node),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_result_node  (out_result_node),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // search state, one copy per model index
  bit    seen_map   [2][MAX_NODES];
  node_t frontier_q [2][MAX_NODES];
  ptr_t  head_p     [2];
  ptr_t  tail_p     [2];
  bit    active     [2];
  bit    mode_r     [2];
  node_t target_r   [2];

  search_word_t   search_words[$];     // words planned but not yet on the port
  search_answer_t awaited_answers[$];  // answers owed by the block, oldest first

  int faults        = 0;
  int quiet_cycles  = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int recv_wait     = 0;
  int send_gap      = 0;
  bit send_calm     = 1'b0;
  bit recv_calm     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Advance one copy of the search state by one word; return the answer it causes.
  function automatic search_answer_t frontier_step(input int s, input cmd_t cmd,
                                                   input node_t nb);
    search_answer_t a;
    node_t popped;
    a = '0;
    case (cmd)
      CMD_START: begin
        // clear the map, mark the root, empty the frontier
        for (int i = 0; i < MAX_NODES; i++) seen_map[s][i] = 1'b0;
        seen_map[s][0] = 1'b1;
        head_p[s] = '0;
        tail_p[s] = '0;
        a.present = 1'b1;
        if (target_r[s] == '0) begin
          active[s] = 1'b0;
          a.kind = KIND_FOUND;
        end else begin
          active[s] = 1'b1;
          a.kind = KIND_FETCH;
        end
      end
      CMD_NEIGHBOR: begin
        // push only unseen nodes; drop a push into a full frontier
        if (active[s] && int'(nb) < MAX_NODES && !seen_map[s][nb]) begin
          seen_map[s][nb] = 1'b1;
          if (tail_p[s] < MAX_NODES) begin
            frontier_q[s][tail_p[s][AW-1:0]] = nb;
            tail_p[s] = tail_p[s] + PTR_W'(1);
          end
        end
      end
      CMD_PAGE_END: begin
        if (active[s]) begin
          a.present = 1'b1;
          if (head_p[s] >= tail_p[s]) begin
            active[s] = 1'b0;
            a.kind = KIND_NOT_FOUND;
          end else begin
            // mode is read at every pop: top of stack or front of queue
            if (!mode_r[s]) begin
              tail_p[s] = tail_p[s] - PTR_W'(1);
              popped = frontier_q[s][tail_p[s][AW-1:0]];
            end else begin
              popped = frontier_q[s][head_p[s][AW-1:0]];
              head_p[s] = head_p[s] + PTR_W'(1);
            end
            a.node = popped;
            if (popped == target_r[s]) begin
              active[s] = 1'b0;
              a.kind = KIND_FOUND;
            end else begin
              a.kind = KIND_FETCH;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  function automatic void apply_reg(input int s, input cfg_idx_t idx, input node_t value);
    if (idx == CFG_MODE) mode_r[s] = value[0];
    else target_r[s] = value;
  endfunction

  function automatic void note_fault(input string msg);
    faults++;
    if (faults <= 10) $display("[%0t] MISMATCH %s", $realtime, msg);
  endfunction

  // Queue one word and advance the planning copy so searches can be steered.
  function automatic void send_word(input cmd_t cmd, input node_t node);
    search_word_t w;
    w.cmd = cmd;
    w.node = node;
    void'(frontier_step(MODEL_PLAN, cmd, node));
    search_words = {search_words, w};
  endfunction

  function automatic node_t pick_node(input int pool);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return node_t'(MAX_NODES - 1);
    if (r == 1) return node_t'($urandom_range(0, MAX_NODES - 1));
    if (r == 2) return '0;
    return node_t'($urandom_range(0, pool - 1));
  endfunction

  function automatic void send_noise();
    case ($urandom_range(0, 2))
      0: send_word(CMD_NEIGHBOR, node_t'($urandom));
      1: send_word(CMD_PAGE_END, node_t'($urandom));
      default: send_word(CMD_UNUSED, node_t'($urandom));
    endcase
  endfunction

  // Wait until every word is taken and answered, then let the pipe and any
  // map sweep run out before touching the registers.
  task automatic settle();
    do @(negedge clk);
    while (search_words.size() != 0 || in_valid || awaited_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (in_stall) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input node_t value);
    settle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(MODEL_PLAN, idx, value);
    @(negedge clk);
  endtask

  // Run searches over a small node pool: start, pages of neighbors, page end.
  // Cap the pages at random so some searches are abandoned by a fresh start.
  task automatic run_searches(input int budget, input int pool);
    int made;
    int pages;
    int nbs;
    made = 0;
    while (made < budget) begin
      send_word(CMD_START, node_t'($urandom));
      made++;
      pages = $urandom_range(2, 40);
      while (active[MODEL_PLAN] && pages != 0 && made < budget) begin
        nbs = $urandom_range(0, 8);
        repeat (nbs) begin
          send_word(CMD_NEIGHBOR, pick_node(pool));
          made++;
        end
        if ($urandom_range(0, 24) == 0) begin
          send_word(CMD_UNUSED, node_t'($urandom));
          made++;
        end
        send_word(CMD_PAGE_END, node_t'($urandom));
        made++;
        pages--;
      end
      // noise words; the block ignores them once the search has ended
      if ($urandom_range(0, 2) == 0) send_noise();
    end
  endtask

  // Driver: offer the next planned word, hold it while stalled, then idle for
  // the drawn gap before the next one.
  always @(posedge clk) begin : drive_words
    search_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (search_words.size() != 0) begin
        w = search_words.pop_front();
        in_valid         <= 1'b1;
        in_cmd           <= w.cmd;
        in_neighbor_node <= w.node;
        if ($urandom_range(0, 29) == 0) send_calm = ~send_calm;
        send_gap <= send_calm ? 0 : $urandom_range(0, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on every accepted word, check every accepted answer,
  // track register writes and drive the receiver stall.
  always @(posedge clk) begin : watch_ports
    search_answer_t a;
    search_answer_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      quiet_cycles++;
      if (cfg_valid && cfg_ready) begin
        apply_reg(MODEL_CHECK, cfg_index, cfg_data);
        quiet_cycles = 0;
      end
      // queue the expectation first so an answer in the same cycle still finds it
      if (in_valid && !in_stall) begin
        a = frontier_step(MODEL_CHECK, in_cmd, in_neighbor_node);
        if (a.present) awaited_answers = {awaited_answers, a};
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (awaited_answers.size() == 0) begin
          note_fault($sformatf("unexpected answer kind %0d node %0d",
                               out_result_kind, out_result_node));
        end else begin
          want = awaited_answers.pop_front();
          if (out_result_kind !== want.kind || out_result_node !== want.node)
            note_fault($sformatf("kind %0d node %0d, expected kind %0d node %0d",
                                 out_result_kind, out_result_node, want.kind, want.node));
        end
        if ($urandom_range(0, 29) == 0) recv_calm = ~recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 8);
      end
      // a hold request starts a long stall counted here, on top of the drawn waits
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait != 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // End the run when no channel has moved for too long.
  initial begin : watchdog
    do @(negedge clk);
    while (quiet_cycles < QUIET_LIMIT);
    $display("graph_search_frontier_engine regression: fail");
    $finish;
  end

  initial begin : stimulus
    int pool;
    int pick;
    for (int s = 0; s < 2; s++) begin
      head_p[s]   = '0;
      tail_p[s]   = '0;
      active[s]   = 1'b0;
      mode_r[s]   = 1'b0;
      target_r[s] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Idle commands, the unused code, then target at the root: found at once.
    send_word(CMD_NEIGHBOR, node_t'(MAX_NODES - 1));
    send_word(CMD_PAGE_END, '0);
    send_word(CMD_UNUSED, 12'hAAA);
    send_word(CMD_START, 12'h555);

    // Depth first toward the top node id; duplicates and the root are dropped,
    // the target is pushed early but found only when popped last.
    write_reg(CFG_TARGET, node_t'(MAX_NODES - 1));
    send_word(CMD_START, '0);
    send_word(CMD_NEIGHBOR, node_t'(MAX_NODES - 1));
    send_word(CMD_NEIGHBOR, 12'd1);
    send_word(CMD_NEIGHBOR, 12'd2);
    send_word(CMD_NEIGHBOR, 12'd1);
    send_word(CMD_NEIGHBOR, 12'd0);
    send_word(CMD_PAGE_END, '0);
    send_word(CMD_PAGE_END, '0);
    send_word(CMD_PAGE_END, '0);
    send_word(CMD_PAGE_END, '0);

    // Breadth first, then switch to depth first in the middle of the search.
    write_reg(CFG_MODE, 12'd1);
    write_reg(CFG_TARGET, 12'd5);
    send_word(CMD_START, '0);
    send_word(CMD_NEIGHBOR, 12'd3);
    send_word(CMD_NEIGHBOR, 12'd7);
    send_word(CMD_NEIGHBOR, 12'd5);
    send_word(CMD_PAGE_END, '0);
    write_reg(CFG_MODE, 12'd0);
    send_word(CMD_PAGE_END, '0);

    // Empty frontier right after the root page: not found.
    write_reg(CFG_TARGET, 12'd9);
    send_word(CMD_START, '0);
    send_word(CMD_PAGE_END, '0);

    // Random searches; registers change only between phases, often mid search.
    for (int ph = 0; ph < PHASES; ph++) begin
      pool = $urandom_range(16, 96);
      if (ph == 0 || $urandom_range(0, 2) != 0)
        write_reg(CFG_MODE, node_t'({11'($urandom), 1'($urandom)}));
      pick = $urandom_range(0, 9);
      if (pick == 0) write_reg(CFG_TARGET, node_t'($urandom));
      else if (pick == 1) write_reg(CFG_TARGET, node_t'(MAX_NODES - 1));
      else write_reg(CFG_TARGET, node_t'($urandom_range(1, pool - 1)));
      run_searches(PHASE_WORDS, pool);
      // hold the receiver while the sender keeps offering this phase's words
      if (ph == 0 || ph == PHASES / 2) hold_requests++;
    end

    settle();
    if (faults == 0 && awaited_answers.size() == 0) begin
      $display("graph_search_frontier_engine regression: pass");
    end else begin
      $display("graph_search_frontier_engine regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/gsfe_pkg.sv
sv/gsfe_ram.sv
sv/gsfe_ctrl.sv
sv/graph_search_frontier_engine.sv
bench/tb.sv
